// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the echo synthesizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that expr holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: invariant violated");
// Check that cons holds whenever ante holds at the same edge.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication violated");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/rdes_pkg.sv -----
// Types, constants and CORDIC helpers for the radar echo synthesizer.
package rdes_pkg;

   localparam int PULSE_DEPTH    = 1024;
   localparam int SAMPLE_WIDTH   = 16;
   localparam int SINE_ADDR_BITS = 10;

   localparam int ADDR_W    = $clog2(PULSE_DEPTH);
   localparam int TX_W      = 16;
   localparam int DELAY_W   = 10;
   localparam int PERIOD_W  = 11;
   localparam int COUNT_W   = 16;
   localparam int PHASE_W   = 32;
   localparam int GAIN_W    = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   localparam logic [PERIOD_W-1:0] MAX_PERIOD = PERIOD_W'(1024);
   localparam logic [PERIOD_W-1:0] MAX_PLEN   =
      (PULSE_DEPTH < 1024) ? PERIOD_W'(PULSE_DEPTH) : PERIOD_W'(1024);

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_DELAY   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PLEN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COUNT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DOPPLER = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN    = 3'd5;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W      = QPTR_W + 1;

   localparam int CORDIC_STEPS = 16;
   localparam int XY_W         = 18;
   localparam int Z_W          = 32;
   localparam logic signed [XY_W-1:0] CORDIC_X0 = 18'sd19898;
   localparam logic signed [XY_W-1:0] TRIG_MAX  = 18'sd32767;

   localparam int ACC_W       = 2 * TX_W + 1;
   localparam int PROD_W      = ACC_W + GAIN_W + 1;
   localparam int ROUND_SHIFT = 23;

   typedef struct packed {
      logic [DELAY_W-1:0]  delay;
      logic [PERIOD_W-1:0] period;
      logic [PERIOD_W-1:0] plen;
      logic [COUNT_W-1:0]  count;
      logic [PHASE_W-1:0]  step;
      logic [GAIN_W-1:0]   gain;
   } cfg_type;

   typedef struct packed {
      logic signed [TX_W-1:0] re;
      logic signed [TX_W-1:0] im;
   } sample_type;

   typedef struct packed {
      logic                      is_tick;
      logic [ADDR_W-1:0]         addr;
      sample_type                sample;
      logic [SINE_ADDR_BITS-1:0] phase;
      logic                      in_range;
      logic                      cpi_last;
   } queue_entry_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QLVL_W-1:0] level;
   } fifo_status_type;

   typedef struct packed {
      sample_type sample;
      logic       cpi_last;
      logic       flip;
   } tag_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      tag_type                tag;
   } cordic_stage_type;

   function automatic logic signed [Z_W-1:0] atan_turn(input int unsigned i);
      logic signed [Z_W-1:0] r;
      unique case (i)
         0:       r = 32'sd536870912;
         1:       r = 32'sd316933406;
         2:       r = 32'sd167458907;
         3:       r = 32'sd85004756;
         4:       r = 32'sd42667331;
         5:       r = 32'sd21354465;
         6:       r = 32'sd10680862;
         7:       r = 32'sd5340245;
         8:       r = 32'sd2670163;
         9:       r = 32'sd1335087;
         10:      r = 32'sd667544;
         11:      r = 32'sd333772;
         12:      r = 32'sd166886;
         13:      r = 32'sd83443;
         14:      r = 32'sd41721;
         15:      r = 32'sd20861;
         default: r = '0;
      endcase
      return r;
   endfunction

   // One rotation step; shifts floor toward minus infinity.
   function automatic cordic_stage_type cordic_step(input cordic_stage_type s,
                                                    input int unsigned i);
      cordic_stage_type       r;
      logic signed [XY_W-1:0] dx;
      logic signed [XY_W-1:0] dy;
      logic signed [Z_W-1:0]  at;
      r  = s;
      dx = s.y >>> i;
      dy = s.x >>> i;
      at = atan_turn(i);
      if (s.z >= 0) begin
         r.x = s.x - dx;
         r.y = s.y + dy;
         r.z = s.z - at;
      end else begin
         r.x = s.x + dx;
         r.y = s.y - dy;
         r.z = s.z + at;
      end
      return r;
   endfunction

endpackage

// ----- hdl/rdes_interfaces.sv -----
// Channel interfaces of the radar echo synthesizer.
interface rdes_req_if import rdes_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   func;
   logic [9:0]             load_index;
   logic signed [TX_W-1:0] tx_real;
   logic signed [TX_W-1:0] tx_imag;
   modport source (output valid, func, load_index, tx_real, tx_imag, input ready);
   modport sink (input valid, func, load_index, tx_real, tx_imag, output ready);
endinterface

interface rdes_rsp_if import rdes_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] echo_real;
   logic signed [SAMPLE_WIDTH-1:0] echo_imag;
   logic                           cpi_last;
   modport source (output valid, echo_real, echo_imag, cpi_last, input ready);
   modport sink (input valid, echo_real, echo_imag, cpi_last, output ready);
endinterface

interface rdes_csr_if import rdes_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/radar_echo_synthesizer.sv -----
// Top level of the point-target radar echo synthesizer.
//
//   channel   direction  transfer when        carries
//   req_bus   in         valid && ready      func, load_index, tx_real, tx_imag
//   rsp_bus   out        valid && ready      echo_real, echo_imag, cpi_last
//   csr_bus   in         valid (ready = 1)   index, data
//
// One item per cycle sustained while rsp_bus is ready; a tick's echo sample goes through
// the pulse store read as it leaves the queue, 16 CORDIC stages, four multiply stages
// and the output register.
// Reset clears counters, phase, queue and pipeline valids and restores register
// defaults; the pulse store is not cleared and must be loaded before use.
// A stalled rsp_bus freezes the back pipeline; the four-entry queue keeps taking
// items until full, then req_bus.ready drops.
`include "assert_macros.svh"

module radar_echo_synthesizer import rdes_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   rdes_req_if.sink    req_bus,
   rdes_rsp_if.source  rsp_bus,
   rdes_csr_if.sink    csr_bus
);

   cfg_type         cfg;
   fifo_status_type fifo_status;
   queue_entry_type push_entry;
   queue_entry_type head;
   logic            push;
   logic            pop;

   rdes_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   rdes_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_bus  (req_bus),
      .q_status (fifo_status),
      .push     (push),
      .entry    (push_entry)
   );

   rdes_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (fifo_status)
   );

   rdes_back u_back (
      .clock    (clock),
      .reset    (reset),
      .gain     (cfg.gain),
      .head     (head),
      .q_status (fifo_status),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

   `ASSERT_ALWAYS(a_queue_level, clock, reset, fifo_status.level <= QLVL_W'(QUEUE_DEPTH))
   `ASSERT_ALWAYS(a_push_is_transfer, clock, reset, push == (req_bus.valid && req_bus.ready))
   `ASSERT_IMPLIES(a_hold_on_stall, clock, reset, rsp_bus.valid && !rsp_bus.ready, !pop)
   `ASSERT_IMPLIES(a_no_pop_empty, clock, reset, fifo_status.empty, !pop)

endmodule

// ----- hdl/rdes_csr.sv -----
// Configuration register file.
module rdes_csr import rdes_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   rdes_csr_if.sink   csr_bus,
   output cfg_type    cfg
);

   cfg_type cfg_ff;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delay  <= '0;
         cfg_ff.period <= PERIOD_W'(1024);
         cfg_ff.plen   <= '0;
         cfg_ff.count  <= COUNT_W'(1);
         cfg_ff.step   <= '0;
         cfg_ff.gain   <= GAIN_W'(256);
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_DELAY:   cfg_ff.delay  <= csr_bus.data[DELAY_W-1:0];
            REG_PERIOD:  cfg_ff.period <= csr_bus.data[PERIOD_W-1:0];
            REG_PLEN:    cfg_ff.plen   <= csr_bus.data[PERIOD_W-1:0];
            REG_COUNT:   cfg_ff.count  <= csr_bus.data[COUNT_W-1:0];
            REG_DOPPLER: cfg_ff.step   <= csr_bus.data[PHASE_W-1:0];
            REG_GAIN:    cfg_ff.gain   <= csr_bus.data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

// ----- hdl/rdes_fifo.sv -----
// Short queue between the front and back parts.
module rdes_fifo import rdes_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   input  logic            pop,
   output queue_entry_type head,
   output fifo_status_type status
);

   queue_entry_type   slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QLVL_W-1:0] level_ff;
   logic              push_ok;
   logic              pop_ok;

   assign status.full  = (level_ff == QLVL_W'(QUEUE_DEPTH));
   assign status.empty = (level_ff == '0);
   assign status.level = level_ff;
   assign push_ok      = push && !status.full;
   assign pop_ok       = pop && !status.empty;
   assign head         = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push_ok) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop_ok) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push_ok && !pop_ok) begin
            level_ff <= level_ff + QLVL_W'(1);
         end else if (pop_ok && !push_ok) begin
            level_ff <= level_ff - QLVL_W'(1);
         end
      end
   end

endmodule

// ----- hdl/rdes_front.sv -----
// Front part: accepts items, tracks pulse timing and classifies ticks.
module rdes_front import rdes_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   rdes_req_if.sink        req_bus,
   input  fifo_status_type q_status,
   output logic            push,
   output queue_entry_type entry
);

   logic [DELAY_W-1:0]  sample_pos_ff;
   logic [DELAY_W-1:0]  sample_pos_in;
   logic [COUNT_W-1:0]  pulse_pos_ff;
   logic [COUNT_W-1:0]  pulse_pos_in;
   logic [PHASE_W-1:0]  phase_ff;
   logic [PHASE_W-1:0]  phase_in;

   logic [PERIOD_W-1:0] period_eff;
   logic [PERIOD_W-1:0] plen_eff;
   logic [COUNT_W-1:0]  count_eff;
   logic [PERIOD_W-1:0] j_ext;
   logic [PERIOD_W-1:0] rel;
   logic                in_range;
   logic                last_sample;
   logic                last_pulse;
   logic                tick;

   assign req_bus.ready = !q_status.full;
   assign push          = req_bus.valid && !q_status.full;
   assign tick          = push && (req_bus.func == FUNC_TICK);

   always_comb begin
      if (cfg.period == '0) begin
         period_eff = PERIOD_W'(1);
      end else if (cfg.period > MAX_PERIOD) begin
         period_eff = MAX_PERIOD;
      end else begin
         period_eff = cfg.period;
      end
      plen_eff  = (cfg.plen > MAX_PLEN) ? MAX_PLEN : cfg.plen;
      count_eff = (cfg.count == '0) ? COUNT_W'(1) : cfg.count;

      j_ext       = {1'b0, sample_pos_ff};
      rel         = j_ext - {1'b0, cfg.delay};
      in_range    = (j_ext >= {1'b0, cfg.delay}) && (rel < plen_eff);
      last_sample = (j_ext + PERIOD_W'(1)) >= period_eff;
      last_pulse  = ({1'b0, pulse_pos_ff} + (COUNT_W + 1)'(1)) >= {1'b0, count_eff};
   end

   always_comb begin
      sample_pos_in = sample_pos_ff + DELAY_W'(1);
      pulse_pos_in  = pulse_pos_ff;
      phase_in      = phase_ff + cfg.step;
      if (last_sample) begin
         sample_pos_in = '0;
         if (last_pulse) begin
            pulse_pos_in = '0;
            phase_in     = '0;
         end else begin
            pulse_pos_in = pulse_pos_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_pos_ff <= '0;
         pulse_pos_ff  <= '0;
         phase_ff      <= '0;
      end else if (tick) begin
         sample_pos_ff <= sample_pos_in;
         pulse_pos_ff  <= pulse_pos_in;
         phase_ff      <= phase_in;
      end
   end

   // Loads travel through the queue too, so store writes keep item order.
   always_comb begin
      entry.is_tick   = (req_bus.func == FUNC_TICK);
      entry.sample.re = req_bus.tx_real;
      entry.sample.im = req_bus.tx_imag;
      entry.phase     = phase_ff[PHASE_W-1 -: SINE_ADDR_BITS];
      entry.in_range  = in_range;
      entry.cpi_last  = last_sample && last_pulse;
      if (req_bus.func == FUNC_TICK) begin
         entry.addr = rel[ADDR_W-1:0];
      end else begin
         entry.addr = req_bus.load_index[ADDR_W-1:0];
      end
   end

endmodule

// ----- hdl/rdes_cordic.sv -----
// Pipelined CORDIC rotator, one rotation step per stage.
module rdes_cordic import rdes_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  cordic_stage_type in_stage,
   output logic             out_valid,
   output cordic_stage_type out_stage
);

   cordic_stage_type src     [CORDIC_STEPS];
   logic             src_vld [CORDIC_STEPS];
   cordic_stage_type st_in   [CORDIC_STEPS];
   cordic_stage_type st_ff   [CORDIC_STEPS];
   logic             vld_ff  [CORDIC_STEPS];

   genvar g;
   for (g = 0; g < CORDIC_STEPS; g++) begin : g_stage
      if (g == 0) begin : g_first
         assign src[g]     = in_stage;
         assign src_vld[g] = in_valid;
      end else begin : g_next
         assign src[g]     = st_ff[g-1];
         assign src_vld[g] = vld_ff[g-1];
      end

      always_comb st_in[g] = cordic_step(src[g], g);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= src_vld[g];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[g] <= st_in[g];
         end
      end
   end

   assign out_valid = vld_ff[CORDIC_STEPS-1];
   assign out_stage = st_ff[CORDIC_STEPS-1];

endmodule

// ----- hdl/rdes_back.sv -----
// Back part: pulse store, Doppler rotation, gain, rounding and saturation.
module rdes_back import rdes_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [GAIN_W-1:0] gain,
   input  queue_entry_type   head,
   input  fifo_status_type   q_status,
   output logic              pop,
   rdes_rsp_if.source        rsp_bus
);

   localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1 << (ROUND_SHIFT - 1));
   localparam logic signed [PROD_W-1:0] SAT_MAX    = PROD_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [PROD_W-1:0] SAT_MIN    = -SAT_MAX - PROD_W'(1);

   sample_type store_mem [PULSE_DEPTH];
   sample_type rd_ff;

   logic                   en;
   logic                   flip;
   logic signed [Z_W-1:0]  z_start;

   logic                   a_valid_ff;
   logic                   a_in_range_ff;
   logic                   a_cpi_ff;
   logic                   a_flip_ff;
   logic signed [Z_W-1:0]  a_z_ff;

   cordic_stage_type       cin;
   logic                   cout_valid;
   cordic_stage_type       cout;

   logic signed [XY_W-1:0] x_clamp;
   logic signed [XY_W-1:0] y_clamp;
   logic signed [XY_W-1:0] c_in;
   logic signed [XY_W-1:0] s_in;

   logic                      p1_valid_ff;
   logic signed [TX_W-1:0]    c_ff;
   logic signed [TX_W-1:0]    s_ff;
   sample_type                p1_sample_ff;
   logic                      p1_cpi_ff;

   logic                      p2_valid_ff;
   logic signed [2*TX_W-1:0]  prc_ff;
   logic signed [2*TX_W-1:0]  pis_ff;
   logic signed [2*TX_W-1:0]  prs_ff;
   logic signed [2*TX_W-1:0]  pic_ff;
   logic                      p2_cpi_ff;

   logic                      p3_valid_ff;
   logic signed [ACC_W-1:0]   re_ff;
   logic signed [ACC_W-1:0]   im_ff;
   logic                      p3_cpi_ff;

   logic                      p4_valid_ff;
   logic signed [PROD_W-1:0]  gre_ff;
   logic signed [PROD_W-1:0]  gim_ff;
   logic                      p4_cpi_ff;

   logic                           out_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] echo_real_ff;
   logic signed [SAMPLE_WIDTH-1:0] echo_imag_ff;
   logic                           cpi_last_ff;

   function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
      input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] sum;
      logic signed [PROD_W-1:0] sh;
      logic signed [SAMPLE_WIDTH-1:0] r;
      sum = v + ROUND_BIAS;
      sh  = sum >>> ROUND_SHIFT;
      if (sh > SAT_MAX) begin
         r = SAT_MAX[SAMPLE_WIDTH-1:0];
      end else if (sh < SAT_MIN) begin
         r = SAT_MIN[SAMPLE_WIDTH-1:0];
      end else begin
         r = sh[SAMPLE_WIDTH-1:0];
      end
      return r;
   endfunction

   // The whole pipeline holds while a finished sample waits.
   assign en  = !out_valid_ff || rsp_bus.ready;
   assign pop = en && !q_status.empty;

   // Fold the second and third quadrants by half a turn, negate afterwards.
   assign flip    = head.phase[SINE_ADDR_BITS-1] ^ head.phase[SINE_ADDR_BITS-2];
   assign z_start = {head.phase[SINE_ADDR_BITS-1] ^ flip,
                     head.phase[SINE_ADDR_BITS-2:0],
                     {(Z_W - SINE_ADDR_BITS){1'b0}}};

   always_ff @(posedge clock) begin
      if (pop && !head.is_tick) begin
         store_mem[head.addr] <= head.sample;
      end
      if (en) begin
         rd_ff <= store_mem[head.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_in_range_ff <= head.in_range;
         a_cpi_ff      <= head.cpi_last;
         a_flip_ff     <= flip;
         a_z_ff        <= z_start;
      end
   end

   always_comb begin
      cin.x            = CORDIC_X0;
      cin.y            = '0;
      cin.z            = a_z_ff;
      cin.tag.sample   = a_in_range_ff ? rd_ff : '0;
      cin.tag.cpi_last = a_cpi_ff;
      cin.tag.flip     = a_flip_ff;
   end

   rdes_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (a_valid_ff),
      .in_stage  (cin),
      .out_valid (cout_valid),
      .out_stage (cout)
   );

   always_comb begin
      if (cout.x > TRIG_MAX) begin
         x_clamp = TRIG_MAX;
      end else if (cout.x < -TRIG_MAX) begin
         x_clamp = -TRIG_MAX;
      end else begin
         x_clamp = cout.x;
      end
      if (cout.y > TRIG_MAX) begin
         y_clamp = TRIG_MAX;
      end else if (cout.y < -TRIG_MAX) begin
         y_clamp = -TRIG_MAX;
      end else begin
         y_clamp = cout.y;
      end
      c_in = cout.tag.flip ? -x_clamp : x_clamp;
      s_in = cout.tag.flip ? -y_clamp : y_clamp;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff         <= c_in[TX_W-1:0];
         s_ff         <= s_in[TX_W-1:0];
         p1_sample_ff <= cout.tag.sample;
         p1_cpi_ff    <= cout.tag.cpi_last;

         prc_ff    <= p1_sample_ff.re * c_ff;
         pis_ff    <= p1_sample_ff.im * s_ff;
         prs_ff    <= p1_sample_ff.re * s_ff;
         pic_ff    <= p1_sample_ff.im * c_ff;
         p2_cpi_ff <= p1_cpi_ff;

         re_ff     <= ACC_W'(prc_ff) - ACC_W'(pis_ff);
         im_ff     <= ACC_W'(prs_ff) + ACC_W'(pic_ff);
         p3_cpi_ff <= p2_cpi_ff;

         gre_ff    <= re_ff * $signed({1'b0, gain});
         gim_ff    <= im_ff * $signed({1'b0, gain});
         p4_cpi_ff <= p3_cpi_ff;

         echo_real_ff <= round_sat(gre_ff);
         echo_imag_ff <= round_sat(gim_ff);
         cpi_last_ff  <= p4_cpi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         p4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff   <= pop && head.is_tick;
         p1_valid_ff  <= cout_valid;
         p2_valid_ff  <= p1_valid_ff;
         p3_valid_ff  <= p2_valid_ff;
         p4_valid_ff  <= p3_valid_ff;
         out_valid_ff <= p4_valid_ff;
      end
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.echo_real = echo_real_ff;
   assign rsp_bus.echo_imag = echo_imag_ff;
   assign rsp_bus.cpi_last  = cpi_last_ff;

endmodule
